### design/mst_pkg.sv
package mst_pkg;

   localparam int AMP_W = 16;
   localparam int FILT_W = 28;
   localparam int FRAC_W = 12;
   localparam int SUM_W = 22;
   localparam int SHOWN_W = 17;
   localparam int BEEP_CNT_W = 5;
   localparam int SA_W = 11;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   localparam int CAL_FRAMES_DEF = 50;
   localparam int DISPLAY_EVERY_DEF = 10;

   localparam logic [11:0] COEF_KEEP = 12'd3686;
   localparam logic [8:0] COEF_NEW = 9'd410;

   localparam logic [0:0] OP_FRAME = 1'b0;
   localparam logic [0:0] OP_TICK = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_DETECT_THR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FERROUS_LIM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BEEP_THR = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SOUND_EN = 2'd3;

   localparam logic [15:0] DETECT_THR_RST = 16'd819;
   localparam logic [15:0] FERROUS_LIM_RST = 16'd4160;
   localparam logic [7:0] BEEP_THR_RST = 8'd15;

   localparam logic [1:0] CLASS_FERROUS = 2'd0;
   localparam logic [1:0] CLASS_NONFERROUS = 2'd1;
   localparam logic [1:0] CLASS_NONE = 2'd2;

   localparam logic [6:0] BEEP_SCALE = 7'd100;
   localparam logic [5:0] BEEP_SLOPE = 6'd45;
   localparam int BEEP_T0 = 3000;
   localparam int BEEP_STEP = 100;
   localparam int BEEP_MIN_PERIOD = 2;
   localparam int BEEP_MAX_PERIOD = 30;

   typedef struct packed {
      logic [0:0] opcode;
      logic [AMP_W-1:0] frame_amp;
      logic signed [AMP_W-1:0] frame_phase;
      logic cal_request;
   } item_type;

   typedef struct packed {
      logic normal;
      logic active;
      logic done;
   } cal_status_type;

   typedef struct packed {
      logic [1:0] metal_class;
      logic signed [SHOWN_W-1:0] shown_amp;
      logic signed [SHOWN_W-1:0] shown_phase;
      logic strobe;
   } frame_view_type;

   typedef struct packed {
      logic clear;
      logic force_low;
   } beep_cfg_type;

endpackage

### design/mst_cal.sv
module mst_cal import mst_pkg::*; #(
   parameter int CAL_FRAMES = CAL_FRAMES_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic frame_go,
   input  logic cal_request,
   input  logic [AMP_W-1:0] frame_amp,
   input  logic signed [AMP_W-1:0] frame_phase,
   output cal_status_type status,
   output logic [AMP_W-1:0] off_amp,
   output logic signed [AMP_W-1:0] off_phase
);

   localparam int CNT_W = $clog2(CAL_FRAMES + 1);
   localparam int DIV_SHIFT = SUM_W + $clog2(CAL_FRAMES);
   localparam int RECIP_W = DIV_SHIFT + 1;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(CAL_FRAMES) - 64'd1) / 64'(CAL_FRAMES));

   logic active_ff, active_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0] amp_sum_ff, amp_sum_in;
   logic signed [SUM_W-1:0] ph_sum_ff, ph_sum_in;
   logic [AMP_W-1:0] off_amp_ff, off_amp_in;
   logic signed [AMP_W-1:0] off_ph_ff, off_ph_in;
   logic [SUM_W-1:0] amp_base, ph_base, ph_mag;
   logic [SUM_W+RECIP_W-1:0] amp_prod, ph_prod;
   logic [AMP_W-1:0] ph_quot;
   logic in_cal, done;

   // offset = floor(sum / CAL_FRAMES) by reciprocal multiply
   assign amp_prod = SUM_W'(amp_sum_ff) * RECIP;
   assign ph_mag = ph_sum_ff[SUM_W-1] ? ~ph_sum_ff : ph_sum_ff;
   assign ph_prod = ph_mag * RECIP;
   assign ph_quot = ph_prod[DIV_SHIFT +: AMP_W];

   always_comb begin
      in_cal = active_ff || cal_request;
      done = 1'b0;
      active_in = active_ff;
      cnt_in = cnt_ff;
      amp_base = (cnt_ff == '0) ? '0 : amp_sum_ff;
      ph_base = (cnt_ff == '0) ? '0 : ph_sum_ff;
      amp_sum_in = amp_sum_ff;
      ph_sum_in = ph_sum_ff;
      off_amp_in = off_amp_ff;
      off_ph_in = off_ph_ff;
      if (frame_go && in_cal) begin
         active_in = 1'b1;
         if (cnt_ff < CNT_W'(CAL_FRAMES)) begin
            amp_sum_in = amp_base + SUM_W'(frame_amp);
            ph_sum_in = $signed(ph_base) + SUM_W'(frame_phase);
            cnt_in = cnt_ff + 1'b1;
         end else begin
            cnt_in = '0;
            active_in = 1'b0;
            done = 1'b1;
            off_amp_in = amp_prod[DIV_SHIFT +: AMP_W];
            off_ph_in = ph_sum_ff[SUM_W-1] ? $signed(~ph_quot) : $signed(ph_quot);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_ff <= '0;
         amp_sum_ff <= '0;
         ph_sum_ff <= '0;
         off_amp_ff <= '0;
         off_ph_ff <= '0;
      end else begin
         active_ff <= active_in;
         cnt_ff <= cnt_in;
         amp_sum_ff <= amp_sum_in;
         ph_sum_ff <= ph_sum_in;
         off_amp_ff <= off_amp_in;
         off_ph_ff <= off_ph_in;
      end
   end

   assign status.normal = !in_cal;
   assign status.active = active_in;
   assign status.done = done;
   assign off_amp = off_amp_ff;
   assign off_phase = off_ph_ff;

   a_idle_count : assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> cnt_ff == '0) else $error("count left over outside calibration");
   a_count_max : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(CAL_FRAMES)) else $error("calibration count overrun");
   a_done_ends : assert property (@(posedge clock) disable iff (reset)
      frame_go && done |=> !active_ff) else $error("calibration still active after done");

endmodule

### design/mst_filter.sv
module mst_filter import mst_pkg::*; #(
   parameter int DISPLAY_EVERY = DISPLAY_EVERY_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic frame_go,
   input  logic [AMP_W-1:0] frame_amp,
   input  logic signed [AMP_W-1:0] frame_phase,
   input  logic [AMP_W-1:0] off_amp,
   input  logic signed [AMP_W-1:0] off_phase,
   input  logic [15:0] detect_thr,
   input  logic signed [15:0] ferrous_lim,
   output logic signed [SHOWN_W-1:0] held_amp,
   output frame_view_type view
);

   localparam int DEC_W = $clog2(DISPLAY_EVERY + 1);

   logic [FILT_W-1:0] amp_filt_ff, amp_filt_in;
   logic signed [FILT_W-1:0] ph_filt_ff, ph_filt_in;
   logic [DEC_W-1:0] dec_ff, dec_in;
   logic [1:0] class_ff, class_in;
   logic signed [SHOWN_W-1:0] held_amp_ff, held_amp_in;
   logic signed [SHOWN_W-1:0] held_ph_ff, held_ph_in;
   logic [FILT_W+11:0] amp_keep;
   logic [AMP_W+8:0] amp_new;
   logic signed [FILT_W+12:0] ph_keep;
   logic signed [AMP_W+9:0] ph_new;
   logic [FILT_W-1:0] amp_filt_c;
   logic signed [FILT_W-1:0] ph_filt_c;
   logic [AMP_W-1:0] fa;
   logic signed [AMP_W-1:0] fp;
   logic signed [SHOWN_W-1:0] amp_c, ph_c;
   logic [1:0] class_c;
   logic strobe;

   // 0.9 / 0.1 low-pass, state at 12 extra fraction bits
   assign amp_keep = amp_filt_ff * COEF_KEEP;
   assign amp_new = frame_amp * COEF_NEW;
   assign ph_keep = ph_filt_ff * $signed({1'b0, COEF_KEEP});
   assign ph_new = frame_phase * $signed({1'b0, COEF_NEW});
   assign amp_filt_c = amp_keep[FILT_W+FRAC_W-1:FRAC_W] + FILT_W'(amp_new);
   assign ph_filt_c = $signed(ph_keep[FILT_W+FRAC_W-1:FRAC_W]) + FILT_W'(ph_new);
   assign fa = amp_filt_c[FILT_W-1:FRAC_W];
   assign fp = ph_filt_c[FILT_W-1:FRAC_W];
   assign amp_c = $signed({1'b0, fa}) - $signed({1'b0, off_amp});
   assign ph_c = $signed({fp[AMP_W-1], fp}) - $signed({off_phase[AMP_W-1], off_phase});

   always_comb begin
      if (amp_c > $signed({1'b0, detect_thr})) begin
         class_c = (ph_c <= $signed({ferrous_lim[15], ferrous_lim})) ?
                   CLASS_FERROUS : CLASS_NONFERROUS;
      end else begin
         class_c = CLASS_NONE;
      end
   end

   always_comb begin
      amp_filt_in = amp_filt_ff;
      ph_filt_in = ph_filt_ff;
      held_amp_in = held_amp_ff;
      held_ph_in = held_ph_ff;
      class_in = class_ff;
      dec_in = dec_ff;
      strobe = 1'b0;
      if (frame_go) begin
         amp_filt_in = amp_filt_c;
         ph_filt_in = ph_filt_c;
         held_amp_in = amp_c;
         held_ph_in = ph_c;
         class_in = class_c;
         if (dec_ff >= DEC_W'(DISPLAY_EVERY - 1)) begin
            strobe = 1'b1;
            dec_in = '0;
         end else begin
            dec_in = dec_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_filt_ff <= '0;
         ph_filt_ff <= '0;
         held_amp_ff <= '0;
         held_ph_ff <= '0;
         class_ff <= CLASS_NONE;
         dec_ff <= '0;
      end else begin
         amp_filt_ff <= amp_filt_in;
         ph_filt_ff <= ph_filt_in;
         held_amp_ff <= held_amp_in;
         held_ph_ff <= held_ph_in;
         class_ff <= class_in;
         dec_ff <= dec_in;
      end
   end

   assign held_amp = held_amp_ff;
   assign view.metal_class = class_in;
   assign view.shown_amp = held_amp_in;
   assign view.shown_phase = held_ph_in;
   assign view.strobe = strobe;

   a_dec_range : assert property (@(posedge clock) disable iff (reset)
      dec_ff < DEC_W'(DISPLAY_EVERY)) else $error("decimator out of range");
   a_class_hold : assert property (@(posedge clock) disable iff (reset)
      !frame_go |=> class_ff == $past(class_ff)) else $error("class moved without a frame");
   a_held_hold : assert property (@(posedge clock) disable iff (reset)
      !frame_go |=> $stable(held_amp_ff)) else $error("held amplitude moved without a frame");

endmodule

### design/mst_beep.sv
module mst_beep import mst_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic tick_go,
   input  logic signed [SHOWN_W-1:0] held_amp,
   input  logic [7:0] beep_thr,
   input  logic sound_en,
   input  beep_cfg_type cfg,
   output logic beep_level
);

   logic [BEEP_CNT_W-1:0] cnt_ff, cnt_in, cnt_inc, period;
   logic beep_ff, beep_in;
   logic [AMP_W+6:0] scaled;
   logic [SA_W-1:0] sa;
   logic [SA_W+5:0] sa45;

   assign scaled = held_amp[AMP_W-1:0] * BEEP_SCALE;
   assign sa = (!held_amp[SHOWN_W-1] && held_amp != '0) ? scaled[AMP_W+6:FRAC_W] : '0;
   assign sa45 = sa * BEEP_SLOPE;
   assign cnt_inc = cnt_ff + 1'b1;

   // period = max(2, (3000 - 45 * sa) / 100), the largest step still reached
   always_comb begin
      period = BEEP_CNT_W'(BEEP_MIN_PERIOD);
      for (int p = BEEP_MIN_PERIOD + 1; p <= BEEP_MAX_PERIOD; p++) begin
         if (sa45 <= (SA_W+6)'(BEEP_T0 - BEEP_STEP * p)) begin
            period = BEEP_CNT_W'(p);
         end
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      beep_in = beep_ff;
      if (cfg.clear) begin
         cnt_in = '0;
         if (cfg.force_low) begin
            beep_in = 1'b0;
         end
      end else if (tick_go && sound_en) begin
         if (cnt_ff == '0) begin
            if (sa > {3'b000, beep_thr}) begin
               beep_in = 1'b1;
            end
         end else if (cnt_ff == BEEP_CNT_W'(1)) begin
            beep_in = 1'b0;
         end
         cnt_in = (cnt_inc >= period) ? '0 : cnt_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         beep_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         beep_ff <= beep_in;
      end
   end

   assign beep_level = beep_in;

   a_quiet_off : assert property (@(posedge clock) disable iff (reset)
      beep_ff |-> sound_en) else $error("beeper driven while sound off");
   a_pulse_start : assert property (@(posedge clock) disable iff (reset)
      $rose(beep_ff) |-> $past(cnt_ff) == '0) else $error("pulse started mid period");
   a_cnt_range : assert property (@(posedge clock) disable iff (reset)
      cnt_ff < BEEP_CNT_W'(BEEP_MAX_PERIOD)) else $error("beep counter out of range");

endmodule

### design/metal_signal_tracker.sv
// channel  dir  ports                           word taken when
// req      in   tvalid tready tdata tuser       tvalid && tready
// rsp      out  tvalid tready tdata             tvalid && tready
// csr      in   wr_en index wr_data             wr_en high
//
// one word per cycle sustained while rsp_tready is high; a taken word is held in the
// item register, and its result is presented from the result register
// the filter, offset and classify path sits between those two registers
// reset is synchronous and restores filters, sums, flags and control registers to defaults;
// the item and result data registers are not reset. rsp_tready low holds the result;
// req_tready drops while both registers are full and the result is held
module metal_signal_tracker import mst_pkg::*; #(
   parameter int CAL_FRAMES = CAL_FRAMES_DEF,
   parameter int DISPLAY_EVERY = DISPLAY_EVERY_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // frame_amp, frame_phase, cal_request
   input  logic [0:0] req_tuser,              // opcode
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // metal_class, shown_amp, shown_phase, display_strobe, calibrating, cal_done,
   // beep_level
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   logic in_valid_ff, in_valid_in;
   item_type item_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic advance, frame_go, tick_go;
   logic [15:0] detect_thr_ff;
   logic signed [15:0] ferrous_lim_ff;
   logic [7:0] beep_thr_ff;
   logic sound_en_ff;
   cal_status_type cal_status;
   frame_view_type view;
   beep_cfg_type beep_cfg;
   logic [AMP_W-1:0] off_amp;
   logic signed [AMP_W-1:0] off_phase;
   logic signed [SHOWN_W-1:0] held_amp;
   logic beep_level;

   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign frame_go = advance && (item_ff.opcode == OP_FRAME);
   assign tick_go = advance && (item_ff.opcode == OP_TICK);

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.opcode <= req_tuser;
         item_ff.frame_amp <= req_tdata[15:0];
         item_ff.frame_phase <= req_tdata[31:16];
         item_ff.cal_request <= req_tdata[32];
      end
      if (advance) begin
         rsp_data_ff <= {beep_level, cal_status.done, cal_status.active, view.strobe,
                         view.shown_phase, view.shown_amp, view.metal_class};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         detect_thr_ff <= DETECT_THR_RST;
         ferrous_lim_ff <= FERROUS_LIM_RST;
         beep_thr_ff <= BEEP_THR_RST;
         sound_en_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_DETECT_THR: begin
               detect_thr_ff <= csr_wr_data;
            end
            CSR_FERROUS_LIM: begin
               ferrous_lim_ff <= csr_wr_data;
            end
            CSR_BEEP_THR: begin
               beep_thr_ff <= csr_wr_data[7:0];
            end
            CSR_SOUND_EN: begin
               sound_en_ff <= csr_wr_data[0];
            end
            default: begin
               sound_en_ff <= sound_en_ff;
            end
         endcase
      end
   end

   assign beep_cfg.clear = csr_wr_en && (csr_index == CSR_SOUND_EN);
   assign beep_cfg.force_low = !csr_wr_data[0];

   mst_cal #(
      .CAL_FRAMES(CAL_FRAMES)
   ) u_cal (
      .clock(clock),
      .reset(reset),
      .frame_go(frame_go),
      .cal_request(item_ff.cal_request),
      .frame_amp(item_ff.frame_amp),
      .frame_phase(item_ff.frame_phase),
      .status(cal_status),
      .off_amp(off_amp),
      .off_phase(off_phase)
   );

   mst_filter #(
      .DISPLAY_EVERY(DISPLAY_EVERY)
   ) u_filter (
      .clock(clock),
      .reset(reset),
      .frame_go(frame_go && cal_status.normal),
      .frame_amp(item_ff.frame_amp),
      .frame_phase(item_ff.frame_phase),
      .off_amp(off_amp),
      .off_phase(off_phase),
      .detect_thr(detect_thr_ff),
      .ferrous_lim(ferrous_lim_ff),
      .held_amp(held_amp),
      .view(view)
   );

   mst_beep u_beep (
      .clock(clock),
      .reset(reset),
      .tick_go(tick_go),
      .held_amp(held_amp),
      .beep_thr(beep_thr_ff),
      .sound_en(sound_en_ff),
      .cfg(beep_cfg),
      .beep_level(beep_level)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   a_done_not_cal : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff[38] && rsp_data_ff[37]))
      else $error("cal done while still calibrating");
   a_done_no_strobe : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff[38] && rsp_data_ff[36]))
      else $error("strobe on a calibration word");
   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("result lost under stall");

endmodule
